// File: rtl/stig_pkg.sv
// Shared types, constants and helpers for the sphere triangle index generator.
`default_nettype none

package stig_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int MAX_RINGS    = 256;
  localparam int CFG_W        = 9;
  localparam int IDX_W        = 16;
  localparam int CNT_W        = 8;

  localparam logic CFG_X_RINGS = 1'b0;
  localparam logic CFG_Y_RINGS = 1'b1;

  localparam logic [CFG_W-1:0] X_RESET = 9'd16;
  localparam logic [CFG_W-1:0] Y_RESET = 9'd16;
  localparam logic [IDX_W-1:0] TOP_RESET = 16'd225;

  typedef enum logic [1:0] {
    SEC_FINISHED = 2'd0,
    SEC_BOTTOM   = 2'd1,
    SEC_MIDDLE   = 2'd2,
    SEC_TOP      = 2'd3
  } section_t;

  typedef struct packed {
    logic [CFG_W-1:0] x;
    logic [CFG_W-1:0] y;
    logic [IDX_W-1:0] top;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    logic             last;
    logic             past;
  } tri_t;

  function automatic logic [CFG_W-1:0] clamp_cfg(input logic [CFG_W-1:0] v,
                                                 input logic [CFG_W-1:0] hi);
    logic [CFG_W-1:0] r;
    if (v < 9'd3) r = 9'd3;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/stig_cfg.sv
// Configuration registers, kept clamped, with the top pole index precomputed.
`default_nettype none

module stig_cfg import stig_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  localparam logic [CFG_W-1:0] XHI = CFG_W'(MAX_SEGMENTS);
  localparam logic [CFG_W-1:0] YHI = CFG_W'(MAX_RINGS);

  logic [CFG_W-1:0]   x_r, x_nxt;
  logic [CFG_W-1:0]   y_r, y_nxt;
  logic [IDX_W-1:0]   top_r, top_nxt;
  logic [2*CFG_W-1:0] prod;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (cfg_we) begin
      if (cfg_index == CFG_X_RINGS) x_nxt = clamp_cfg(cfg_data, XHI);
      else y_nxt = clamp_cfg(cfg_data, YHI);
    end
    // The top pole sits after all ring vertices: X*(Y-2)+1.
    prod    = x_nxt * (y_nxt - 9'd2);
    top_nxt = prod[IDX_W-1:0] + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= X_RESET;
      y_r   <= Y_RESET;
      top_r <= TOP_RESET;
    end else if (cfg_we) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      top_r <= top_nxt;
    end
  end

  assign cfg = '{x: x_r, y: y_r, top: top_r};

endmodule

`default_nettype wire

// File: rtl/stig_seq.sv
// Section and counter state with the triangle index logic for one item.
`default_nettype none

module stig_seq import stig_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic accept,
  input  wire logic restart,
  input  wire cfg_t cfg,
  output tri_t      tri_o
);

  section_t         sec_r, sec_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic             half_r, half_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;

  section_t         sec_e;
  logic [CNT_W-1:0] row_e, col_e;
  logic             half_e;
  logic [IDX_W-1:0] base_e;
  logic [CFG_W-1:0] col_inc, row_inc;
  logic [IDX_W-1:0] xx, jj, bj;
  logic             not_seam;

  always_comb begin
    sec_e  = sec_r;
    row_e  = row_r;
    col_e  = col_r;
    half_e = half_r;
    base_e = base_r;
    if (restart) begin
      sec_e  = SEC_BOTTOM;
      row_e  = '0;
      col_e  = '0;
      half_e = 1'b0;
      base_e = '0;
    end

    col_inc  = {1'b0, col_e} + 9'd1;
    row_inc  = {1'b0, row_e} + 9'd1;
    xx       = {{(IDX_W-CFG_W){1'b0}}, cfg.x};
    jj       = {{(IDX_W-CNT_W){1'b0}}, col_e};
    bj       = base_e + jj;
    not_seam = {1'b0, col_e} < (cfg.x - 9'd1);

    tri_o    = '0;
    sec_nxt  = sec_e;
    row_nxt  = row_e;
    col_nxt  = col_e;
    half_nxt = half_e;
    base_nxt = base_e;

    unique case (sec_e)
      SEC_BOTTOM: begin
        tri_o.b = jj + 16'd1;
        tri_o.c = (col_inc < cfg.x) ? jj + 16'd2 : 16'd1;
        if (col_inc >= cfg.x) begin
          col_nxt  = '0;
          row_nxt  = '0;
          base_nxt = '0;
          half_nxt = 1'b0;
          sec_nxt  = (cfg.y > 9'd3) ? SEC_MIDDLE : SEC_TOP;
        end else begin
          col_nxt = col_inc[CNT_W-1:0];
        end
      end
      SEC_MIDDLE: begin
        if (not_seam) begin
          if (!half_e) begin
            tri_o.a = bj + 16'd2;
            tri_o.b = bj + 16'd1;
            tri_o.c = bj + 16'd2 + xx;
          end else begin
            tri_o.a = bj + 16'd2 + xx;
            tri_o.b = bj + 16'd1;
            tri_o.c = bj + 16'd1 + xx;
          end
        end else begin
          // Seam quad wraps back to the first vertex of the row.
          if (!half_e) begin
            tri_o.a = base_e + xx + 16'd1;
            tri_o.b = base_e + 16'd1;
          end else begin
            tri_o.a = base_e + 16'd1;
            tri_o.b = base_e + xx;
          end
          tri_o.c = base_e + {xx[IDX_W-2:0], 1'b0};
        end
        if (!half_e) begin
          half_nxt = 1'b1;
        end else begin
          half_nxt = 1'b0;
          if (col_inc >= cfg.x) begin
            col_nxt  = '0;
            row_nxt  = row_inc[CNT_W-1:0];
            base_nxt = base_e + xx;
            if (row_inc >= (cfg.y - 9'd3)) begin
              sec_nxt = SEC_TOP;
              row_nxt = '0;
            end
          end else begin
            col_nxt = col_inc[CNT_W-1:0];
          end
        end
      end
      SEC_TOP: begin
        if (not_seam) begin
          tri_o.a = cfg.top;
          tri_o.b = cfg.top - jj - 16'd1;
          tri_o.c = cfg.top - jj - 16'd2;
        end else begin
          tri_o.a    = cfg.top - 16'd1;
          tri_o.b    = cfg.top;
          tri_o.c    = cfg.top - xx;
          tri_o.last = 1'b1;
        end
        if (col_inc >= cfg.x) begin
          col_nxt = '0;
          sec_nxt = SEC_FINISHED;
        end else begin
          col_nxt = col_inc[CNT_W-1:0];
        end
      end
      SEC_FINISHED: begin
        tri_o.past = 1'b1;
      end
      default: begin
        tri_o.past = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sec_r  <= SEC_FINISHED;
      row_r  <= '0;
      col_r  <= '0;
      half_r <= 1'b0;
      base_r <= '0;
    end else if (accept) begin
      sec_r  <= sec_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      half_r <= half_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/stig_out.sv
// Result register: holds one triangle until the consumer takes it.
`default_nettype none

module stig_out import stig_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire tri_t tri_i,
  input  wire logic out_stall,
  output logic      out_valid,
  output tri_t      tri_o
);

  logic valid_r;
  tri_t tri_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) tri_r <= tri_i;
  end

  assign out_valid = valid_r;
  assign tri_o     = tri_r;

endmodule

`default_nettype wire

// File: rtl/sphere_triangle_index_generator_top.sv
// An accepted request's triangle is in the result register in the next cycle.
// Throughput: one triangle per cycle unless stalled; results free as they are taken.
// The section counters and index adders settle between request and result register.
// Reset (rst_n low, synchronous): no result pending, X = Y = 16, section finished,
// so a request without restart answers past_end until the first restart.
`default_nettype none

module sphere_triangle_index_generator_top import stig_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_restart,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [IDX_W-1:0]      out_index_a,
  output logic [IDX_W-1:0]      out_index_b,
  output logic [IDX_W-1:0]      out_index_c,
  output logic                  out_last_triangle,
  output logic                  out_past_end,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  cfg_t cfg;
  tri_t tri_next, tri_held;
  logic accept;

  // A new item may enter whenever the result register is empty or being drained.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  stig_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  stig_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .restart (in_restart),
    .cfg     (cfg),
    .tri_o   (tri_next)
  );

  stig_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .tri_i     (tri_next),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .tri_o     (tri_held)
  );

  assign out_index_a       = tri_held.a;
  assign out_index_b       = tri_held.b;
  assign out_index_c       = tri_held.c;
  assign out_last_triangle = tri_held.last;
  assign out_past_end      = tri_held.past;

  a_past_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_past_end |->
      out_index_a == '0 && out_index_b == '0 && out_index_c == '0 && !out_last_triangle)
    else $error("past_end result carries nonzero fields");

  a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_restart |=>
      out_valid && !out_past_end && out_index_a == '0 && out_index_b == 16'd1)
    else $error("restart did not yield the first bottom fan triangle");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result register free");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_index_a) && $stable(out_past_end))
    else $error("stalled result changed");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// Self-checking testbench for the sphere triangle index generator.
`timescale 1ns / 1ps

module tb_top import stig_pkg::*; ();

  localparam int RUN_LIMIT = 500000;
  localparam int HOLD_CYCLES = 60;
  localparam int PHASE_ITEMS = 475;
  localparam int SEQ_CAP = 200;

  class triangle_ledger;
    logic [CFG_W-1:0] x_reg;
    logic [CFG_W-1:0] y_reg;
    section_t         sec;
    int unsigned      row_n;
    int unsigned      col_n;
    bit               second_tri;
    logic [IDX_W-1:0] row_base;
    tri_t             expected_triangles[$];
    int               errors;

    function new();
      x_reg = X_RESET;
      y_reg = Y_RESET;
      sec = SEC_FINISHED;
      row_n = 0;
      col_n = 0;
      second_tri = 1'b0;
      row_base = '0;
      errors = 0;
    endfunction

    function void set_config(logic [CFG_W-1:0] x, logic [CFG_W-1:0] y);
      x_reg = x;
      y_reg = y;
    endfunction

    function int unsigned ring_limit(logic [CFG_W-1:0] v, int unsigned hi);
      if (v < 3) return 3;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned sphere_size();
      return 2 * ring_limit(x_reg, MAX_SEGMENTS) * (ring_limit(y_reg, MAX_RINGS) - 2);
    endfunction

    function int unsigned outstanding();
      return expected_triangles.size();
    endfunction

    // Works out the triangle that one accepted request produces.
    function void note_request(logic restart);
      int unsigned nx, ny, top, a, b, c;
      tri_t t;
      nx = ring_limit(x_reg, MAX_SEGMENTS);
      ny = ring_limit(y_reg, MAX_RINGS);
      top = nx * (ny - 2) + 1;
      a = 0;
      b = 0;
      c = 0;
      t = '0;
      if (restart) begin
        sec = SEC_BOTTOM;
        row_n = 0;
        col_n = 0;
        second_tri = 1'b0;
        row_base = '0;
      end
      case (sec)
        SEC_BOTTOM: begin
          b = col_n + 1;
          c = (col_n + 1 < nx) ? col_n + 2 : 1;
          col_n++;
          if (col_n >= nx) begin
            col_n = 0;
            row_n = 0;
            row_base = '0;
            second_tri = 1'b0;
            sec = (ny > 3) ? SEC_MIDDLE : SEC_TOP;
          end
        end
        SEC_MIDDLE: begin
          // A column at or past the last one closes the row across the seam.
          if (col_n < nx - 1) begin
            if (!second_tri) begin
              a = row_base + col_n + 2;
              b = row_base + col_n + 1;
              c = row_base + col_n + 2 + nx;
            end else begin
              a = row_base + col_n + 2 + nx;
              b = row_base + col_n + 1;
              c = row_base + col_n + 1 + nx;
            end
          end else if (!second_tri) begin
            a = row_base + nx + 1;
            b = row_base + 1;
            c = row_base + 2 * nx;
          end else begin
            a = row_base + 1;
            b = row_base + nx;
            c = row_base + 2 * nx;
          end
          if (!second_tri) begin
            second_tri = 1'b1;
          end else begin
            second_tri = 1'b0;
            col_n++;
            if (col_n >= nx) begin
              col_n = 0;
              row_n++;
              row_base = row_base + nx[IDX_W-1:0];
              if (row_n >= ny - 3) begin
                sec = SEC_TOP;
                row_n = 0;
              end
            end
          end
        end
        SEC_TOP: begin
          if (col_n < nx - 1) begin
            a = top;
            b = top - col_n - 1;
            c = top - col_n - 2;
          end else begin
            a = top - 1;
            b = top;
            c = top - nx;
            t.last = 1'b1;
          end
          col_n++;
          if (col_n >= nx) begin
            col_n = 0;
            sec = SEC_FINISHED;
          end
        end
        default: t.past = 1'b1;
      endcase
      t.a = a[IDX_W-1:0];
      t.b = b[IDX_W-1:0];
      t.c = c[IDX_W-1:0];
      expected_triangles = {expected_triangles, t};
    endfunction

    function void compare_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_triangle(tri_t got);
      tri_t want;
      if (expected_triangles.size() == 0) begin
        $error("triangle %0d %0d %0d arrived with no request outstanding",
               got.a, got.b, got.c);
        errors++;
        return;
      end
      want = expected_triangles.pop_front();
      compare_field("index_a", want.a, got.a);
      compare_field("index_b", want.b, got.b);
      compare_field("index_c", want.c, got.c);
      compare_field("last_triangle", IDX_W'(want.last), IDX_W'(got.last));
      compare_field("past_end", IDX_W'(want.past), IDX_W'(got.past));
    endfunction
  endclass

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_restart = 1'b0;
  logic             out_stall = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_X_RINGS;
  logic [CFG_W-1:0] cfg_data = '0;
  logic             in_stall;
  logic             out_valid;
  logic [IDX_W-1:0] out_index_a;
  logic [IDX_W-1:0] out_index_b;
  logic [IDX_W-1:0] out_index_c;
  logic             out_last_triangle;
  logic             out_past_end;

  triangle_ledger ledger = new();
  int cycle_count = 0;
  int sent_items = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  sphere_triangle_index_generator_top uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_index_a       (out_index_a),
    .out_index_b       (out_index_b),
    .out_index_c       (out_index_c),
    .out_last_triangle (out_last_triangle),
    .out_past_end      (out_past_end),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_valid && !in_stall) ledger.note_request(in_restart);
    if (rst_n && out_valid && !out_stall) begin
      ledger.check_triangle({out_index_a, out_index_b, out_index_c,
                             out_last_triangle, out_past_end});
    end
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  initial begin
    wait (cycle_count == RUN_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic send_request(input logic restart);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (in_stall);
    sent_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_W-1:0] x, input logic [CFG_W-1:0] y);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_X_RINGS;
    cfg_data <= x;
    @(posedge clk);
    cfg_index <= CFG_Y_RINGS;
    cfg_data <= y;
    @(posedge clk);
    cfg_we <= 1'b0;
    ledger.set_config(x, y);
  endtask

  // Mostly small spheres so that whole sequences finish; now and then any value.
  function automatic logic [CFG_W-1:0] pick_ring();
    case ($urandom_range(0, 9))
      0: return CFG_W'($urandom_range(0, 511));
      1: return 9'd256;
      default: return CFG_W'($urandom_range(3, 8));
    endcase
  endfunction

  // One pass through a sphere and a few requests past its end, cut at SEQ_CAP, with the odd
  // stray restart and sometimes a configuration change partway through.
  // No more than budget items are sent.
  task automatic run_sequence(input int unsigned budget);
    int unsigned length;
    int unsigned switch_at;
    length = ledger.sphere_size() + $urandom_range(0, 3);
    if (length > SEQ_CAP) length = SEQ_CAP;
    if (length >= budget) length = budget - 1;
    switch_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, length) : length + 1;
    send_request($urandom_range(0, 7) != 0);
    for (int k = 1; k <= length; k++) begin
      if (k == switch_at) write_config(pick_ring(), pick_ring());
      send_request($urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    int phase_goal;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // No restart yet, so these find the sequence already finished.
    send_request(1'b0);
    send_request(1'b0);
    // Smallest sphere, run to its end and several past it.
    write_config(9'd3, 9'd3);
    send_request(1'b1);
    repeat (12) send_request(1'b0);
    // Out-of-range values clamp; shrinking X mid-fan ends the bottom fan early.
    write_config(9'd511, 9'd0);
    send_request(1'b1);
    repeat (4) send_request(1'b0);
    write_config(9'd2, 9'd0);
    repeat (3) send_request(1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 17 : (phase == 1) ? 73 : 0;
      recv_idle_pct = (phase == 0) ? 73 : (phase == 1) ? 17 : 0;
      phase_goal = sent_items + PHASE_ITEMS;
      write_config(pick_ring(), pick_ring());
      if (phase != 1) hold_requests++;
      while (sent_items < phase_goal) begin
        run_sequence(phase_goal - sent_items);
        write_config(pick_ring(), pick_ring());
      end
    end

    drain();
    if (ledger.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/stig_pkg.sv
rtl/stig_cfg.sv
rtl/stig_seq.sv
rtl/stig_out.sv
rtl/sphere_triangle_index_generator_top.sv
test/tb_top.sv
